>>> rtl/upps_pkg.sv
// shared types and constants for the usb port power supervisor
package upps_pkg;

    localparam int PORT_W = 2;
    localparam int CUR_W  = 10;
    localparam int LOW_W  = 10;
    localparam int TICK_W = 8;
    localparam int EV_W   = 2;
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 10;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE       = 2'd0;
    localparam logic [EV_W-1:0] EV_ATTACH_ON  = 2'd1;
    localparam logic [EV_W-1:0] EV_DETACH_OFF = 2'd2;
    localparam logic [EV_W-1:0] EV_IDLE_OFF   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_LOW_CURRENT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_PERSIST     = 1'b1;

    // register reset values
    localparam logic [LOW_W-1:0]  LOW_CURRENT_RST = 10'd25;
    localparam logic [TICK_W-1:0] PERSIST_RST     = 8'd30;

    // one per-port entry of the state memory
    typedef struct packed {
        logic              last_attached;
        logic              port_enabled;
        logic [TICK_W-1:0] idle_ticks;
    } t_port_state;

endpackage

>>> rtl/usb_port_power_supervisor.sv
// top level of the usb port power supervisor
//
// Per-port charger power supervisor. Each input transaction is one update tick
// for one port: port index, cable-attached level and a raw current-sense ADC
// count. Per port the block keeps the last attach level, the power enable and
// an idle tick count in a small synchronous state memory. A rising attach level
// switches the port on, a falling level switches it off; either edge clears
// the idle count. While enabled, a count below low_current_counts adds one idle
// tick, and reaching persist_ticks switches the port off until it is attached
// again. Every input transaction gives exactly one result transaction with the
// port index, the new enable state and the event code (last action wins). A
// port index at or above NUM_PORTS changes nothing and reports off, no event.
// Rate: one transaction per clock while results are taken. The state memory
// is read on the accept edge, the entry is updated and written back when
// stage 1 advances, and a write-to-read bypass covers back-to-back ticks for
// the same port. A result passes through stage 1 and then the output register
// before o_out_valid rises, and it stays there until the receiver takes it.
// A result held by the receiver stalls the input once stage 1 is also full.
// The configuration port writes low_current_counts (index 0) and
// persist_ticks (index 1) with no handshake; write it only while idle.
module usb_port_power_supervisor #(
    parameter int NUM_PORTS = 4,
    parameter int ADC_BITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [upps_pkg::PORT_W-1:0]   i_port_index,
    input  logic                          i_cable_attached,
    input  logic [upps_pkg::CUR_W-1:0]    i_current_counts,
    // result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [upps_pkg::PORT_W-1:0]   o_port_out,
    output logic                          o_power_on,
    output logic [upps_pkg::EV_W-1:0]     o_event_code,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [upps_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [upps_pkg::CFG_DW-1:0]   i_cfg_wdata
);

    // memory address width, at least one bit
    localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    // adc bits that take part in the compare
    localparam int CB = (ADC_BITS < upps_pkg::CUR_W) ? ADC_BITS : upps_pkg::CUR_W;
    localparam logic [upps_pkg::CUR_W-1:0] CUR_MASK =
        upps_pkg::CUR_W'((33'd1 << CB) - 33'd1);

    // configuration registers
    logic [upps_pkg::LOW_W-1:0]  r_low_current_counts;
    logic [upps_pkg::TICK_W-1:0] r_persist_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_current_counts <= upps_pkg::LOW_CURRENT_RST;
            r_persist_ticks      <= upps_pkg::PERSIST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                upps_pkg::CFG_LOW_CURRENT: r_low_current_counts <= i_cfg_wdata;
                upps_pkg::CFG_PERSIST:
                    r_persist_ticks <= i_cfg_wdata[upps_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic in_acc;
    logic s1_adv;
    logic r_s1_valid;
    logic r_out_valid;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // port index widened so any address width can be taken from it
    logic [AW+upps_pkg::PORT_W-1:0] port_ext;
    logic [AW-1:0]                  rd_addr;
    logic                           in_range;

    assign port_ext = {{AW{1'b0}}, i_port_index};
    assign rd_addr  = port_ext[AW-1:0];
    assign in_range = (32'(i_port_index) < NUM_PORTS);

    // stage 1 holds the tick whose state entry is being read
    logic [upps_pkg::PORT_W-1:0] r_s1_port;
    logic [AW-1:0]               r_s1_addr;
    logic                        r_s1_in_range;
    logic                        r_s1_att;
    logic [upps_pkg::CUR_W-1:0]  r_s1_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_port     <= i_port_index;
            r_s1_addr     <= rd_addr;
            r_s1_in_range <= in_range;
            r_s1_att      <= i_cable_attached;
            r_s1_cur      <= i_current_counts & CUR_MASK;
        end
    end

    // state memory, one entry per port, with registered read
    upps_pkg::t_port_state mem [NUM_PORTS];
    upps_pkg::t_port_state r_rd_data;
    logic [NUM_PORTS-1:0]  r_ent_vld;   // entry written since reset
    logic                  r_rd_vld;

    logic                  wr_en;
    upps_pkg::t_port_state n_state;

    assign wr_en = s1_adv && r_s1_in_range;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_addr] <= n_state;
        end
        if (in_acc) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_ent_vld[r_s1_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_rd_vld <= r_ent_vld[rd_addr];
            end
        end
    end

    // bypass: the write landing on the same edge as the read is not in the read data
    logic                  r_fwd_vld;
    logic [AW-1:0]         r_fwd_addr;
    upps_pkg::t_port_state r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (in_acc) begin
            r_fwd_vld <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_state;
        end
    end

    upps_pkg::t_port_state cur_state;

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur_state = r_fwd_data;
        end else if (r_rd_vld) begin
            cur_state = r_rd_data;
        end else begin
            cur_state = '0;
        end
    end

    // per-tick update of the port entry
    logic [upps_pkg::EV_W-1:0]   n_event;
    logic [upps_pkg::TICK_W:0]   idle_inc;

    assign idle_inc = {1'b0, cur_state.idle_ticks} + 9'd1;

    always_comb begin
        n_state = cur_state;
        n_event = upps_pkg::EV_NONE;

        // attach edges
        if (!cur_state.last_attached && r_s1_att) begin
            n_state.port_enabled = 1'b1;
            n_state.idle_ticks   = '0;
            n_event              = upps_pkg::EV_ATTACH_ON;
        end else if (cur_state.last_attached && !r_s1_att) begin
            n_state.port_enabled = 1'b0;
            n_state.idle_ticks   = '0;
            n_event              = upps_pkg::EV_DETACH_OFF;
        end
        n_state.last_attached = r_s1_att;

        // idle-current monitoring, also in the tick that switched the port on
        if (n_state.port_enabled) begin
            if (r_s1_cur < r_low_current_counts) begin
                if (idle_inc >= {1'b0, r_persist_ticks}) begin
                    n_state.port_enabled = 1'b0;
                    n_state.idle_ticks   = '0;
                    n_event              = upps_pkg::EV_IDLE_OFF;
                end else if (idle_inc[upps_pkg::TICK_W]) begin
                    n_state.idle_ticks = '1;
                end else begin
                    n_state.idle_ticks = idle_inc[upps_pkg::TICK_W-1:0];
                end
            end else begin
                n_state.idle_ticks = '0;
            end
        end
    end

    // output register
    logic [upps_pkg::PORT_W-1:0] r_out_port;
    logic                        r_out_power;
    logic [upps_pkg::EV_W-1:0]   r_out_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_port <= r_s1_port;
            if (r_s1_in_range) begin
                r_out_power <= n_state.port_enabled;
                r_out_event <= n_event;
            end else begin
                // unknown port: nothing changes, report off with no event
                r_out_power <= 1'b0;
                r_out_event <= upps_pkg::EV_NONE;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_port_out   = r_out_port;
    assign o_power_on   = r_out_power;
    assign o_event_code = r_out_event;

endmodule

>>> dv/usb_port_power_supervisor_test.sv
// self-checking testbench for the usb port power supervisor
module usb_port_power_supervisor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PORTS     = 4;
    localparam int ADC_BITS      = 10;
    // cycles to let pass after the last result before touching the registers
    localparam int SETTLE_CYCLES = 4;
    // length of the forced receiver hold-off, long enough to back up the pipe
    localparam int HOLD_OFF_CYCLES = 64;

    // one result transaction as seen on the output channel
    typedef struct packed {
        logic [upps_pkg::PORT_W-1:0] port;
        logic                        power_on;
        logic [upps_pkg::EV_W-1:0]   ev;
    } t_port_report;

    // tracks per-port power state and holds the reports still owed by the block
    class port_power_scoreboard;
        upps_pkg::t_port_state       ports [NUM_PORTS];
        logic [upps_pkg::LOW_W-1:0]  low_thr;
        logic [upps_pkg::TICK_W-1:0] persist_lim;
        t_port_report                expected_reports [$];
        int unsigned                 mismatch_count;

        function new();
            foreach (ports[p]) ports[p] = '0;
            low_thr        = upps_pkg::LOW_CURRENT_RST;
            persist_lim    = upps_pkg::PERSIST_RST;
            mismatch_count = 0;
        endfunction

        function void set_limits(logic [upps_pkg::LOW_W-1:0] low,
                                 logic [upps_pkg::TICK_W-1:0] persist);
            low_thr     = low;
            persist_lim = persist;
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        // apply one accepted tick to the port state and queue the report it owes
        function void note_tick(logic [upps_pkg::PORT_W-1:0] port, logic att,
                                logic [upps_pkg::CUR_W-1:0] cur);
            upps_pkg::t_port_state s;
            t_port_report          r;
            int unsigned           n;
            r.port     = port;
            r.power_on = 1'b0;
            r.ev       = upps_pkg::EV_NONE;
            if (int'(port) < NUM_PORTS) begin
                s = ports[port];
                // cable edges first
                if (!s.last_attached && att) begin
                    s.port_enabled = 1'b1;
                    s.idle_ticks   = '0;
                    r.ev           = upps_pkg::EV_ATTACH_ON;
                end else if (s.last_attached && !att) begin
                    s.port_enabled = 1'b0;
                    s.idle_ticks   = '0;
                    r.ev           = upps_pkg::EV_DETACH_OFF;
                end
                s.last_attached = att;
                // idle current monitor runs in the same tick, even right after attach
                if (s.port_enabled) begin
                    if (cur < low_thr) begin
                        n = int'(s.idle_ticks) + 1;
                        if (n >= int'(persist_lim)) begin
                            s.port_enabled = 1'b0;
                            s.idle_ticks   = '0;
                            r.ev           = upps_pkg::EV_IDLE_OFF;
                        end else begin
                            s.idle_ticks = (n > 255) ? 8'd255 : upps_pkg::TICK_W'(n);
                        end
                    end else begin
                        s.idle_ticks = '0;
                    end
                end
                ports[port] = s;
                r.power_on  = s.port_enabled;
            end
            expected_reports.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_report(logic [upps_pkg::PORT_W-1:0] port, logic power_on,
                          logic [upps_pkg::EV_W-1:0] ev);
            t_port_report e;
            if (expected_reports.size() == 0) begin
                report($sformatf("result for port %0d with nothing outstanding", port));
                return;
            end
            e = expected_reports.pop_front();
            if (port !== e.port)
                report($sformatf("port_out %0d, want %0d", port, e.port));
            if (power_on !== e.power_on)
                report($sformatf("port %0d power_on %0b, want %0b", e.port, power_on,
                                 e.power_on));
            if (ev !== e.ev)
                report($sformatf("port %0d event_code %0d, want %0d", e.port, ev, e.ev));
        endtask
    endclass

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_in_valid       = 1'b0;
    logic                          o_in_ready;
    logic [upps_pkg::PORT_W-1:0]   i_port_index     = '0;
    logic                          i_cable_attached = 1'b0;
    logic [upps_pkg::CUR_W-1:0]    i_current_counts = '0;
    logic                          o_out_valid;
    logic                          i_out_ready      = 1'b0;
    logic [upps_pkg::PORT_W-1:0]   o_port_out;
    logic                          o_power_on;
    logic [upps_pkg::EV_W-1:0]     o_event_code;
    logic                          i_cfg_we         = 1'b0;
    logic [upps_pkg::CFG_AW-1:0]   i_cfg_index      = '0;
    logic [upps_pkg::CFG_DW-1:0]   i_cfg_wdata      = '0;

    port_power_scoreboard sb;

    // sender burst bookkeeping and the cable level last sent on each port
    int unsigned          burst_left  = 0;
    int unsigned          max_gap     = 2;
    logic [NUM_PORTS-1:0] cable_level = '0;
    // raised by the sequence to make the receiver hold off for a long stretch
    bit                   hold_off_req = 1'b0;

    usb_port_power_supervisor #(
        .NUM_PORTS (NUM_PORTS),
        .ADC_BITS  (ADC_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_port_index     (i_port_index),
        .i_cable_attached (i_cable_attached),
        .i_current_counts (i_current_counts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_port_out       (o_port_out),
        .o_power_on       (o_power_on),
        .o_event_code     (o_event_code),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #200us;
        $display("CHECKS FAILED");
        $finish;
    end

    // output monitor: every accepted result transaction is checked in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_report(o_port_out, o_power_on, o_event_code);
    end

    // receiver: ready follows a random 8-bit mask, repeated for a random stretch;
    // an all-ones mask gives stall-free stretches
    initial begin
        logic [7:0]  mask;
        int unsigned span;
        int unsigned k;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                // long hold-off so the block fills and stalls its input
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                mask = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 255));
                span = $urandom_range(8, 40);
                for (k = 0; k < span && !hold_off_req; k++) begin
                    i_out_ready <= mask[k % 8];
                    @(posedge i_clk);
                end
            end
        end
    end

    // offer one tick and hold it until the handshake; bursts with random gaps
    task automatic send_tick(input logic [upps_pkg::PORT_W-1:0] port, input logic att,
                             input logic [upps_pkg::CUR_W-1:0] cur);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_port_index     <= port;
        i_cable_attached <= att;
        i_current_counts <= cur;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_tick(port, att, cur);
        cable_level[port] = att;
    endtask

    // stop offering and wait for every outstanding result, then let the settle time pass
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // registers only change with the block idle
    task automatic set_config(input logic [upps_pkg::LOW_W-1:0] low,
                              input logic [upps_pkg::TICK_W-1:0] persist);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= upps_pkg::CFG_LOW_CURRENT;
        i_cfg_wdata <= upps_pkg::CFG_DW'(low);
        @(posedge i_clk);
        i_cfg_index <= upps_pkg::CFG_PERSIST;
        i_cfg_wdata <= upps_pkg::CFG_DW'(persist);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limits(low, persist);
    endtask

    // random ticks: mostly steady cable levels with occasional plug and unplug,
    // currents biased below the idle threshold by idle_pct, plus some pure noise
    task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                             input bit mid_pause);
        logic [upps_pkg::PORT_W-1:0] port;
        logic                        att;
        logic [upps_pkg::CUR_W-1:0]  cur;
        int unsigned                 i;
        for (i = 0; i < count; i++) begin
            if (mid_pause && i == count / 2)
                drain_results();
            port = upps_pkg::PORT_W'($urandom_range(0, NUM_PORTS - 1));
            if ($urandom_range(0, 99) < 10) begin
                att = 1'($urandom_range(0, 1));
                cur = upps_pkg::CUR_W'($urandom_range(0, 1023));
            end else begin
                att = cable_level[port];
                if ($urandom_range(0, 99) < 8)
                    att = ~att;
                if ($urandom_range(0, 99) < idle_pct && sb.low_thr != 0)
                    cur = upps_pkg::CUR_W'($urandom_range(0, int'(sb.low_thr) - 1));
                else
                    cur = upps_pkg::CUR_W'($urandom_range(int'(sb.low_thr), 1023));
            end
            send_tick(port, att, cur);
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: attach at full scale, idle counting around the threshold,
        // count cleared at exactly the threshold, then detach and stay detached
        send_tick(2'd0, 1'b1, 10'd1023);
        send_tick(2'd0, 1'b1, 10'd0);
        send_tick(2'd0, 1'b1, 10'd24);
        send_tick(2'd0, 1'b1, 10'd25);
        send_tick(2'd0, 1'b0, 10'd0);
        send_tick(2'd0, 1'b0, 10'd512);
        send_tick(2'd1, 1'b1, 10'd25);

        // persistence of one: attach with idle current goes straight back off
        set_config(upps_pkg::LOW_CURRENT_RST, 8'd1);
        send_tick(2'd1, 1'b0, 10'd100);
        send_tick(2'd1, 1'b1, 10'd0);
        send_tick(2'd1, 1'b1, 10'd0);

        // persistence of zero: first idle tick switches off
        set_config(upps_pkg::LOW_CURRENT_RST, 8'd0);
        send_tick(2'd2, 1'b1, 10'd3);

        // zero threshold: nothing is ever idle
        set_config(10'd0, 8'd255);
        send_tick(2'd3, 1'b1, 10'd0);
        send_tick(2'd3, 1'b1, 10'd0);

        // full-scale threshold, longest persistence: build up an idle count
        set_config(10'd1023, 8'd255);
        send_tick(2'd3, 1'b1, 10'd1022);
        send_tick(2'd3, 1'b1, 10'd1023);
        send_tick(2'd2, 1'b0, 10'd0);
        repeat (5) send_tick(2'd2, 1'b1, 10'd0);

        // limit lowered below the running count: next idle tick switches off
        set_config(10'd1023, 8'd3);
        send_tick(2'd2, 1'b1, 10'd1);

        // random part, one phase per register setting
        max_gap = 4;
        set_config(upps_pkg::LOW_CURRENT_RST, upps_pkg::PERSIST_RST);
        run_phase(58, 90, 1'b0);

        // back-to-back offers while the receiver holds off
        max_gap = 0;
        set_config(upps_pkg::LOW_W'($urandom_range(1, 1023)),
                   upps_pkg::TICK_W'($urandom_range(2, 8)));
        hold_off_req = 1'b1;
        run_phase(58, 70, 1'b0);

        max_gap = 3;
        set_config(10'd0, 8'd255);
        run_phase(58, 50, 1'b0);

        // sender pauses midway until everything has come back
        max_gap = 5;
        set_config(10'd1023, 8'd1);
        run_phase(58, 80, 1'b1);

        max_gap = 2;
        set_config(upps_pkg::LOW_W'($urandom_range(0, 1023)), 8'd0);
        run_phase(58, 60, 1'b0);

        // long idle runs at the widest limit, then a much lower limit
        max_gap = 1;
        set_config(10'd1023, 8'd255);
        run_phase(58, 95, 1'b0);
        set_config(10'd1023, 8'd4);
        run_phase(20, 95, 1'b0);

        max_gap = 3;
        set_config(upps_pkg::LOW_W'($urandom_range(1, 1023)),
                   upps_pkg::TICK_W'($urandom_range(2, 12)));
        run_phase(58, 75, 1'b0);

        drain_results();
        if (sb.mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/upps_pkg.sv
rtl/usb_port_power_supervisor.sv
dv/usb_port_power_supervisor_test.sv
